>>> rtl/ispfpe_pkg.sv
`timescale 1ns / 1ps

package ispfpe_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] CFG_VERIFY_MODE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_SIZE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECTOR_SHIFT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_UID   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ID    = 3'd4;

  localparam logic [7:0] OP_ERASE   = 8'ha4;
  localparam logic [7:0] OP_PROGRAM = 8'ha5;
  localparam logic [7:0] OP_VERIFY  = 8'ha6;
  localparam logic [7:0] ERASE_LEN  = 8'h04;
  localparam logic [7:0] TRAIL_LEN  = 8'h05;
  localparam logic [7:0] HDR_EXTRA  = 8'h05;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic        verify_mode;
    logic [23:0] image_size;
    logic [4:0]  sector_shift;
    logic [63:0] device_uid;
    logic [7:0]  device_id;
  } cfg_t;

  typedef struct packed {
    logic        excess;
    logic        erase;
    logic        header;
    logic        trailer;
    logic        prog;
    logic [7:0]  data;
    logic        data_end;
    logic [7:0]  len5;
    logic [23:0] offset;
    logic [23:0] sectors;
    logic [23:0] size;
  } desc_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ERASE,
    PH_HEADER,
    PH_DATA,
    PH_TRAILER,
    PH_EXCESS
  } phase_t;

endpackage

>>> rtl/ispfpe_if.sv
`timescale 1ns / 1ps

interface ispfpe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] image_byte;

  modport source (output valid, output image_byte, input ready);
  modport sink (input valid, input image_byte, output ready);
endinterface

interface ispfpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_end;
  logic       run_last;
  logic       excess_error;

  modport source (output valid, output out_byte, output packet_end, output run_last,
                  output excess_error, input ready);
  modport sink (input valid, input out_byte, input packet_end, input run_last,
                input excess_error, output ready);
endinterface

>>> rtl/ispfpe_front.sv
`timescale 1ns / 1ps

module ispfpe_front import ispfpe_pkg::*; #(
  parameter int CHUNK_BYTES = 56
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  ispfpe_in_if.sink   in_ch,
  input  logic        q_full,
  output logic        q_push,
  output desc_t       q_data
);

  localparam logic [23:0] ChunkLen = 24'(CHUNK_BYTES);

  logic [23:0] offset_r, offset_nxt;
  logic [5:0]  cpos_r, cpos_nxt;

  logic [5:0]  cpos_fix;
  logic [23:0] chunk_start;
  logic [23:0] remain;
  logic [5:0]  len;
  logic        chunk_end;
  logic [7:0]  uid_sum;
  logic [7:0]  key;
  logic [23:0] round_mask;
  logic [23:0] sectors;
  logic        excess;
  logic        prog;
  logic        accept;
  logic [23:0] offset_inc;

  always_comb begin
    cpos_fix    = ({18'd0, cpos_r} > offset_r) ? 6'd0 : cpos_r;
    chunk_start = offset_r - {18'd0, cpos_fix};
    remain      = cfg.image_size - chunk_start;
    len         = (remain < ChunkLen) ? remain[5:0] : ChunkLen[5:0];
    chunk_end   = ({1'b0, cpos_fix} + 7'd1) >= {1'b0, len};

    uid_sum = 8'd0;
    for (int i = 0; i < 8; i++) begin
      uid_sum = uid_sum + cfg.device_uid[8*i +: 8];
    end
    key = (cpos_fix[2:0] == 3'b111) ? uid_sum + cfg.device_id : uid_sum;

    round_mask = ~(24'hffffff << cfg.sector_shift);
    sectors    = (cfg.image_size >> cfg.sector_shift)
               + {23'd0, |(cfg.image_size & round_mask)};

    prog       = !cfg.verify_mode;
    excess     = offset_r >= cfg.image_size;
    offset_inc = offset_r + 24'd1;
  end

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_push      = accept;

  always_comb begin
    q_data          = '0;
    q_data.excess   = excess;
    q_data.erase    = (offset_r == 24'd0) && prog;
    q_data.header   = (cpos_fix == 6'd0);
    q_data.trailer  = (offset_inc >= cfg.image_size) && prog;
    q_data.prog     = prog;
    q_data.data     = in_ch.image_byte ^ key;
    q_data.data_end = chunk_end;
    q_data.len5     = {2'b00, len} + HDR_EXTRA;
    q_data.offset   = offset_r;
    q_data.sectors  = sectors;
    q_data.size     = cfg.image_size;
  end

  always_comb begin
    offset_nxt = offset_r;
    cpos_nxt   = cpos_r;
    if (accept && !excess) begin
      offset_nxt = offset_inc;
      cpos_nxt   = chunk_end ? 6'd0 : cpos_fix + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      cpos_r   <= '0;
    end else begin
      offset_r <= offset_nxt;
      cpos_r   <= cpos_nxt;
    end
  end

endmodule

>>> rtl/ispfpe_queue.sv
`timescale 1ns / 1ps

module ispfpe_queue import ispfpe_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output desc_t head_data
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  desc_t           mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wptr_r, wptr_nxt;
  logic [PtrW-1:0] rptr_r, rptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full       = (count_r == CntW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("pop from empty queue");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1) else $error("count slip");

endmodule

>>> rtl/ispfpe_back.sv
`timescale 1ns / 1ps

module ispfpe_back import ispfpe_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  desc_t        q_head,
  output logic         q_pop,
  ispfpe_out_if.source out_ch
);

  phase_t     phase_r, phase_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_end_r, out_end_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_err_r, out_err_nxt;

  phase_t     cur_ph;
  phase_t     next_ph;
  logic       fire;
  logic       seg_done;
  logic       last;
  logic [7:0] sel_byte;
  logic       sel_end;
  logic       sel_err;

  assign fire = q_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    if (phase_r != PH_IDLE) begin
      cur_ph = phase_r;
    end else if (q_head.excess) begin
      cur_ph = PH_EXCESS;
    end else if (q_head.erase) begin
      cur_ph = PH_ERASE;
    end else if (q_head.header) begin
      cur_ph = PH_HEADER;
    end else begin
      cur_ph = PH_DATA;
    end
  end

  always_comb begin
    sel_byte = 8'h00;
    sel_end  = 1'b0;
    sel_err  = 1'b0;
    seg_done = 1'b0;
    last     = 1'b0;
    next_ph  = PH_IDLE;
    unique case (cur_ph)
      PH_ERASE: begin
        seg_done = (cnt_r == 3'd6);
        sel_end  = seg_done;
        next_ph  = q_head.header ? PH_HEADER : PH_DATA;
        unique case (cnt_r)
          3'd0:    sel_byte = OP_ERASE;
          3'd1:    sel_byte = ERASE_LEN;
          3'd3:    sel_byte = q_head.sectors[7:0];
          3'd4:    sel_byte = q_head.sectors[15:8];
          3'd5:    sel_byte = q_head.sectors[23:16];
          default: sel_byte = 8'h00;
        endcase
      end
      PH_HEADER: begin
        seg_done = (cnt_r == 3'd7);
        next_ph  = PH_DATA;
        unique case (cnt_r)
          3'd0:    sel_byte = q_head.prog ? OP_PROGRAM : OP_VERIFY;
          3'd1:    sel_byte = q_head.len5;
          3'd3:    sel_byte = q_head.offset[7:0];
          3'd4:    sel_byte = q_head.offset[15:8];
          3'd5:    sel_byte = q_head.offset[23:16];
          default: sel_byte = 8'h00;
        endcase
      end
      PH_DATA: begin
        seg_done = 1'b1;
        sel_byte = q_head.data;
        sel_end  = q_head.data_end;
        last     = !q_head.trailer;
        next_ph  = PH_TRAILER;
      end
      PH_TRAILER: begin
        seg_done = (cnt_r == 3'd7);
        sel_end  = seg_done;
        last     = seg_done;
        unique case (cnt_r)
          3'd0:    sel_byte = OP_PROGRAM;
          3'd1:    sel_byte = TRAIL_LEN;
          3'd3:    sel_byte = q_head.size[7:0];
          3'd4:    sel_byte = q_head.size[15:8];
          3'd5:    sel_byte = q_head.size[23:16];
          default: sel_byte = 8'h00;
        endcase
      end
      PH_EXCESS: begin
        seg_done = 1'b1;
        sel_err  = 1'b1;
        last     = 1'b1;
      end
      default: begin
        seg_done = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_end_nxt   = out_end_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    q_pop         = 1'b0;
    if (fire) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = sel_byte;
      out_end_nxt   = sel_end;
      out_last_nxt  = last;
      out_err_nxt   = sel_err;
      if (last) begin
        q_pop     = 1'b1;
        phase_nxt = PH_IDLE;
        cnt_nxt   = 3'd0;
      end else if (seg_done) begin
        phase_nxt = next_ph;
        cnt_nxt   = 3'd0;
      end else begin
        phase_nxt = cur_ph;
        cnt_nxt   = cnt_r + 3'd1;
      end
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_end_r  <= out_end_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.packet_end   = out_end_r;
  assign out_ch.run_last     = out_last_r;
  assign out_ch.excess_error = out_err_r;

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> fire && last) else $error("queue popped before last byte");
  a_erase_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERASE |-> cnt_r < 3'd7) else $error("erase packet overrun");
  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> cnt_r == 3'd0) else $error("byte count left over");
  a_excess_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_last_r && !out_end_r && out_byte_r == 8'h00)
    else $error("malformed excess result");

endmodule

>>> rtl/isp_flash_packet_encoder_top.sv
`timescale 1ns / 1ps

// flash loader packet encoder
// in_ch takes one plain image byte per transfer; out_ch gives the command packet
// stream one byte per transfer with packet_end, run_last and excess_error flags.
// cfg_we / cfg_index / cfg_data write the session registers (verify mode, image
// size, sector shift, uid, chip id); write them only while the block is idle.
// an accepted byte is classified at once and queued (two entries); the packet
// sequencer then sends its 1 to 24 result bytes, one per cycle when not stalled,
// through an output register. the first result of a byte passes the queue entry
// and the output register before it is valid. a byte with no erase, header
// or trailer gives one result, so input runs at one byte per cycle
// in steady state with the receiver ready; a chunk opener adds 8 header bytes.
// when the receiver stalls the output register holds, the queue fills and
// in_ch.ready falls; nothing is dropped.
// reset (rst_n low, synchronous) restores register defaults, clears the byte
// offset and chunk position, empties the queue and drops out_ch.valid.
// bytes past image_size yield one flagged result each; a larger size resumes.
module isp_flash_packet_encoder_top import ispfpe_pkg::*; #(
  parameter int CHUNK_BYTES = 56
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ispfpe_in_if.sink              in_ch,
  ispfpe_out_if.source           out_ch
);

  cfg_t  cfg_r, cfg_nxt;
  logic  q_push, q_full, q_pop, q_valid;
  desc_t q_in, q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERIFY_MODE:  cfg_nxt.verify_mode  = cfg_data[0];
        CFG_IMAGE_SIZE:   cfg_nxt.image_size   = cfg_data[23:0];
        CFG_SECTOR_SHIFT: cfg_nxt.sector_shift = cfg_data[4:0];
        CFG_DEVICE_UID:   cfg_nxt.device_uid   = cfg_data;
        CFG_DEVICE_ID:    cfg_nxt.device_id    = cfg_data[7:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.verify_mode  <= 1'b0;
      cfg_r.image_size   <= 24'd64;
      cfg_r.sector_shift <= 5'd10;
      cfg_r.device_uid   <= '0;
      cfg_r.device_id    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ispfpe_front #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  ispfpe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  ispfpe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

>>> test/packet_stream_checker.sv
`timescale 1ns / 1ps

module packet_stream_checker import ispfpe_pkg::*; #(
  parameter int CHUNK_BYTES = 56
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ispfpe_in_if                   in_mon,
  ispfpe_out_if                  out_mon,
  output int                     fail_count,
  output int                     pending,
  output int                     checked
);

  typedef struct {
    logic [7:0] value;
    logic       packet_end;
    logic       run_last;
    logic       excess_error;
  } stream_byte_t;

  stream_byte_t expected_q[$];
  stream_byte_t want;

  cfg_t        regs;
  logic [23:0] offset;
  logic [5:0]  chunk_pos;

  function automatic void put_byte(input logic [7:0] value, input logic pkt_end);
    stream_byte_t sb;
    sb.value        = value;
    sb.packet_end   = pkt_end;
    sb.run_last     = 1'b0;
    sb.excess_error = 1'b0;
    expected_q.push_back(sb);
  endfunction

  function automatic void put_word(input logic [31:0] w);
    put_byte(w[7:0], 1'b0);
    put_byte(w[15:8], 1'b0);
    put_byte(w[23:16], 1'b0);
    put_byte(w[31:24], 1'b0);
  endfunction

  function automatic logic [7:0] scramble_key(input logic [5:0] pos);
    logic [7:0] s;
    s = 8'd0;
    for (int i = 0; i < 8; i++) s = s + regs.device_uid[8*i +: 8];
    if (pos[2:0] == 3'd7) s = s + regs.device_id;
    return s;
  endfunction

  function automatic void encode_image_byte(input logic [7:0] plain);
    stream_byte_t sb;
    logic         prog;
    logic [63:0]  sectors;
    logic [23:0]  start;
    logic [23:0]  rem;
    int           len;
    logic         last;
    if (offset >= regs.image_size) begin
      sb.value        = 8'd0;
      sb.packet_end   = 1'b0;
      sb.run_last     = 1'b1;
      sb.excess_error = 1'b1;
      expected_q.push_back(sb);
      return;
    end
    prog = !regs.verify_mode;
    if (offset == 24'd0 && prog) begin
      sectors = ({40'd0, regs.image_size} + (64'd1 << regs.sector_shift) - 64'd1)
                >> regs.sector_shift;
      put_byte(OP_ERASE, 1'b0);
      put_byte(ERASE_LEN, 1'b0);
      put_byte(8'd0, 1'b0);
      put_byte(sectors[7:0], 1'b0);
      put_byte(sectors[15:8], 1'b0);
      put_byte(sectors[23:16], 1'b0);
      put_byte(sectors[31:24], 1'b1);
    end
    if ({18'd0, chunk_pos} > offset) chunk_pos = 6'd0;
    start = offset - {18'd0, chunk_pos};
    rem   = regs.image_size - start;
    len   = (rem < CHUNK_BYTES) ? int'(rem) : CHUNK_BYTES;
    if (chunk_pos == 6'd0) begin
      put_byte(prog ? OP_PROGRAM : OP_VERIFY, 1'b0);
      put_byte(8'(len + 5), 1'b0);
      put_byte(8'((len + 5) >> 8), 1'b0);
      put_word({8'd0, offset});
      put_byte(8'd0, 1'b0);
    end
    last = (int'(chunk_pos) + 1 >= len);
    put_byte(plain ^ scramble_key(chunk_pos), last);
    offset    = offset + 24'd1;
    chunk_pos = last ? 6'd0 : chunk_pos + 6'd1;
    if (offset >= regs.image_size && prog) begin
      put_byte(OP_PROGRAM, 1'b0);
      put_byte(TRAIL_LEN, 1'b0);
      put_byte(8'd0, 1'b0);
      put_word({8'd0, regs.image_size});
      put_byte(8'd0, 1'b1);
    end
    expected_q[expected_q.size() - 1].run_last = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.verify_mode  = 1'b0;
      regs.image_size   = 24'd64;
      regs.sector_shift = 5'd10;
      regs.device_uid   = 64'd0;
      regs.device_id    = 8'd0;
      offset            = 24'd0;
      chunk_pos         = 6'd0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_VERIFY_MODE:  regs.verify_mode  = cfg_data[0];
          CFG_IMAGE_SIZE:   regs.image_size   = cfg_data[23:0];
          CFG_SECTOR_SHIFT: regs.sector_shift = cfg_data[4:0];
          CFG_DEVICE_UID:   regs.device_uid   = cfg_data;
          CFG_DEVICE_ID:    regs.device_id    = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        checked++;
        if (expected_q.size() == 0) begin
          $error("unexpected packet byte %02h with no transfer pending", out_mon.out_byte);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_mon.out_byte !== want.value) begin
            $error("out_byte: expected %02h, actual %02h", want.value, out_mon.out_byte);
            fail_count++;
          end
          if (out_mon.packet_end !== want.packet_end) begin
            $error("packet_end: expected %0b, actual %0b", want.packet_end,
                   out_mon.packet_end);
            fail_count++;
          end
          if (out_mon.run_last !== want.run_last) begin
            $error("run_last: expected %0b, actual %0b", want.run_last, out_mon.run_last);
            fail_count++;
          end
          if (out_mon.excess_error !== want.excess_error) begin
            $error("excess_error: expected %0b, actual %0b", want.excess_error,
                   out_mon.excess_error);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) encode_image_byte(in_mon.image_byte);
    end
    pending = expected_q.size();
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ispfpe_pkg::*;

  localparam int CHUNK_BYTES = 56;
  localparam int IMAGE_BYTES = 470;
  localparam int CYCLE_LIMIT = 1000000;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  ispfpe_in_if  in_ch ();
  ispfpe_out_if out_ch ();

  int fail_count;
  int pending;
  int checked;
  int cycle_count;

  logic [23:0] img_offset;
  logic [23:0] img_size;
  int          in_image;
  int          beyond;
  int          sessions;
  int          count;
  int          kind;
  int          out_wait;
  bit          in_calm;
  bit          out_calm;
  logic [7:0]  directed_bytes[15] = '{8'h00, 8'hff, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                      8'h20, 8'h40, 8'h80, 8'hfe, 8'h55, 8'haa, 8'h7f,
                                      8'h3c};

  isp_flash_packet_encoder_top #(
    .CHUNK_BYTES(CHUNK_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  packet_stream_checker #(
    .CHUNK_BYTES(CHUNK_BYTES)
  ) i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d packet bytes still due", cycle_count, pending);
    $display("TEST FAILED");
    $finish;
  end

  // idle stretches switch on and off now and then
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == CFG_IMAGE_SIZE) img_size = value[23:0];
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] plain);
    int w;
    w = draw_gap(in_calm);
    if (w > 0) begin
      in_ch.valid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.image_byte <= plain;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    if (img_offset < img_size) begin
      img_offset++;
      in_image++;
    end else begin
      beyond++;
    end
    @(negedge clk);
  endtask

  // block drained before any register write
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      out_wait = draw_gap(out_calm);
      if (out_wait > 0) begin
        out_ch.ready <= 1'b0;
        repeat (out_wait) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_VERIFY_MODE;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.image_byte <= 8'd0;
    img_offset = 24'd0;
    img_size   = 24'd64;
    in_image   = 0;
    beyond     = 0;
    sessions   = 0;
    in_calm    = 1'b0;
    out_calm   = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // one-byte image: erase, header, data and trailer from one transfer
    write_reg(CFG_VERIFY_MODE, 64'd0);
    write_reg(CFG_IMAGE_SIZE, 64'd1);
    write_reg(CFG_SECTOR_SHIFT, 64'd0);
    write_reg(CFG_DEVICE_UID, '1);
    write_reg(CFG_DEVICE_ID, 64'hff);
    cfg_we <= 1'b0;
    send_byte(8'h00);
    send_byte(8'hff);
    settle();
    sessions++;

    write_reg(CFG_IMAGE_SIZE, 64'(img_offset + 24'd15));
    write_reg(CFG_DEVICE_UID, 64'h0123_4567_89ab_cdef);
    write_reg(CFG_DEVICE_ID, 64'h5a);
    cfg_we <= 1'b0;
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    send_byte(8'h81);
    settle();
    sessions++;

    // verify mode, then cut the open chunk short
    write_reg(CFG_VERIFY_MODE, 64'd1);
    write_reg(CFG_IMAGE_SIZE, 64'(img_offset + 24'd10));
    write_reg(CFG_SECTOR_SHIFT, 64'd31);
    write_reg(CFG_DEVICE_UID, 64'd0);
    write_reg(CFG_DEVICE_ID, 64'd0);
    cfg_we <= 1'b0;
    repeat (4) send_byte(8'($urandom_range(0, 255)));
    settle();
    write_reg(CFG_IMAGE_SIZE, 64'(img_offset + 24'd2));
    cfg_we <= 1'b0;
    repeat (2) send_byte(8'($urandom_range(0, 255)));
    settle();
    sessions++;

    while (in_image < IMAGE_BYTES) begin
      write_reg(CFG_VERIFY_MODE, 64'($urandom_range(0, 1)));
      kind = $urandom_range(0, 5);
      if (kind == 0) write_reg(CFG_DEVICE_UID, '0);
      else if (kind == 1) write_reg(CFG_DEVICE_UID, '1);
      else write_reg(CFG_DEVICE_UID, {$urandom(), $urandom()});
      write_reg(CFG_DEVICE_ID, 64'($urandom_range(0, 255)));
      write_reg(CFG_SECTOR_SHIFT, 64'($urandom_range(0, 31)));
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        write_reg(CFG_IMAGE_SIZE, 64'hff_ffff);
        count = $urandom_range(1, 80);
      end else if (kind == 1 && img_offset > 24'd1) begin
        write_reg(CFG_IMAGE_SIZE, 64'($urandom_range(1, int'(img_offset))));
        count = $urandom_range(1, 3);
      end else begin
        write_reg(CFG_IMAGE_SIZE, 64'(img_offset + 24'($urandom_range(1, 100))));
        count = int'(img_size - img_offset);
        if ($urandom_range(0, 3) == 0) count = $urandom_range(1, count);
        else if ($urandom_range(0, 3) == 0) count++;
      end
      cfg_we <= 1'b0;
      repeat (count) send_byte(8'($urandom_range(0, 255)));
      settle();
      sessions++;
    end

    repeat (20) @(negedge clk);
    $display("%0d image bytes and %0d bytes past the image end over %0d sessions",
             in_image, beyond, sessions);
    $display("%0d packet bytes checked, %0d failures", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ispfpe_pkg.sv
rtl/ispfpe_if.sv
rtl/ispfpe_front.sv
rtl/ispfpe_queue.sv
rtl/ispfpe_back.sv
rtl/isp_flash_packet_encoder_top.sv
test/packet_stream_checker.sv
test/tb_top.sv
